### rtl/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

   localparam int KEY_COUNT   = 12;
   localparam int CODE_W      = 4;
   localparam int PASSWORD_W  = 12;
   localparam int ENTRY_DEPTH = 3;
   localparam int COUNT_W     = 2;
   localparam int LED_W       = 3;
   localparam int BYTE_W      = 8;

   localparam logic [CODE_W-1:0] NO_KEY     = 4'd15;
   localparam logic [BYTE_W-1:0] BLANK      = 8'hFF;
   localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'hFE;
   localparam logic [LED_W-1:0]  LED_WHITE  = 3'b000;
   localparam logic [LED_W-1:0]  LED_OFF    = 3'b111;

   typedef logic [CODE_W-1:0] code_type;

   typedef enum logic [1:0] {
      ACCESS_NONE    = 2'd0,
      ACCESS_ALLOWED = 2'd1,
      ACCESS_DENIED  = 2'd2
   } access_type;

   typedef struct packed {
      logic     found;
      code_type code;
   } key_type;

   // packed so that key_event lands in bit 0
   typedef struct packed {
      logic [BYTE_W-1:0] segment_pattern;
      logic [BYTE_W-1:0] digit_select;
      logic              display_update;
      logic              blue_drive_n;
      logic              green_drive_n;
      logic              red_drive_n;
      logic              lock_state;
      access_type        access_result;
      code_type          key_code;
      logic              key_event;
   } result_type;

   function automatic logic [BYTE_W-1:0] seg_of(code_type c);
      logic [BYTE_W-1:0] s;
      unique case (c)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         4'd10:   s = 8'hBF;
         4'd11:   s = 8'h88;
         default: s = BLANK;
      endcase
      return s;
   endfunction

   // active-low rgb: bit 2 red, bit 1 green, bit 0 blue
   function automatic logic [LED_W-1:0] colour_of(code_type c);
      logic [LED_W-1:0] l;
      unique case (c)
         4'd0:    l = 3'd2;
         4'd1:    l = 3'd3;
         4'd2:    l = 3'd5;
         4'd3:    l = 3'd6;
         4'd4:    l = 3'd1;
         4'd5:    l = 3'd2;
         4'd6:    l = 3'd4;
         4'd7:    l = 3'd3;
         4'd8:    l = 3'd5;
         4'd9:    l = 3'd6;
         4'd10:   l = 3'd1;
         4'd11:   l = 3'd4;
         default: l = LED_WHITE;
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

### rtl/keypad_combination_lock_top.sv
// keypad combination lock for a 4x3 pad
// req channel: one transaction per scan tick, req_tdata[11:0] is the map of
// pressed keys (bit row*3+col). rsp channel: one transaction per scan tick
// carrying the key event, access check result, lock state, active-low rgb
// led drives and the seven-segment bytes.
// the password lives in one register at csr address 0, three key codes of
// four bits each, first key in the low nibble; write it only while idle.
// the result of each accepted transaction is registered in the output buffer
// before it shows on rsp. one transaction per cycle while req_tready is
// high; key encode, password compare and display mapping are all
// combinational between the lock state registers and the output register.
// reset: locked, no key held, led white, password 0x321, output empty.
// a stalled rsp side is absorbed by a two-entry output buffer; req_tready
// drops only when both entries hold results.
`default_nettype none

module keypad_combination_lock_top
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 3
)(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] pressed_keys

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] key_event, [4:1] key_code, [6:5] access_result, [7] lock_state,
   // [8] red_drive_n, [9] green_drive_n, [10] blue_drive_n,
   // [11] display_update, [19:12] digit_select, [27:20] segment_pattern
   output logic [31:0]      rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int RESULT_W = $bits(result_type);

   logic [PASSWORD_W-1:0] password_ff;
   logic                  csr_write;
   logic                  accept;
   key_type               key;
   result_type            result;
   result_type            rsp_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? '0 : {{(32 - PASSWORD_W){1'b0}}, password_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         password_ff <= 12'd801;
      end else if (csr_write && !csr_paddr[2]) begin
         password_ff <= csr_pwdata[PASSWORD_W-1:0];
      end
   end

   assign accept = req_tvalid && req_tready;

   kcl_key_encode u_encode (
      .pressed_keys (req_tdata[KEY_COUNT-1:0]),
      .key          (key)
   );

   kcl_lock_ctrl #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .key      (key),
      .password (password_ff),
      .result   (result)
   );

   kcl_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {{(32 - RESULT_W){1'b0}}, rsp_data};

   a_allowed_unlocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.access_result == ACCESS_ALLOWED |-> !rsp_data.lock_state)
      else $error("access allowed while still locked");

   a_blank_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data.display_update |->
         rsp_data.digit_select == BLANK && rsp_data.segment_pattern == BLANK)
      else $error("display bytes not blank without update");

   a_no_code_without_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data.key_event |->
         rsp_data.key_code == '0 && rsp_data.access_result == ACCESS_NONE)
      else $error("key code or check without a key event");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with the output empty");

endmodule

`default_nettype wire

### rtl/kcl_key_encode.sv
`default_nettype none

module kcl_key_encode
   import kcl_pkg::*;
(
   input  wire logic [KEY_COUNT-1:0] pressed_keys,
   output key_type                   key
);

   // bottom row is star, zero, hash
   function automatic code_type code_of_index(logic [CODE_W-1:0] idx);
      code_type c;
      unique case (idx)
         4'd9:    c = 4'd10;
         4'd10:   c = 4'd0;
         4'd11:   c = 4'd11;
         default: c = idx + 4'd1;
      endcase
      return c;
   endfunction

   // scan from the top so the lowest set bit wins
   always_comb begin
      key.found = 1'b0;
      key.code  = '0;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (pressed_keys[i]) begin
            key.found = 1'b1;
            key.code  = code_of_index(CODE_W'(i));
         end
      end
   end

endmodule

`default_nettype wire

### rtl/kcl_lock_ctrl.sv
`default_nettype none

module kcl_lock_ctrl
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 3
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire key_type               key,
   input  wire logic [PASSWORD_W-1:0] password,
   output result_type                 result
);

   code_type           last_key_ff, last_key_in;
   code_type           entry_ff [ENTRY_DEPTH];
   code_type           entry_in [ENTRY_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               locked_ff, locked_in;
   logic [LED_W-1:0]   led_ff, led_in;
   logic               match;
   code_type           cand;

   // compare against the buffer as it will be with the new code written in
   always_comb begin
      match = 1'b1;
      cand  = '0;
      for (int i = 0; i < ENTRY_DEPTH; i++) begin
         cand = (COUNT_W'(i) == count_ff) ? key.code : entry_ff[i];
         if (i < CODE_LENGTH && cand != password[CODE_W*i +: CODE_W]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      last_key_in = last_key_ff;
      entry_in    = entry_ff;
      count_in    = count_ff;
      locked_in   = locked_ff;
      led_in      = led_ff;

      result                 = '0;
      result.access_result   = ACCESS_NONE;
      result.digit_select    = BLANK;
      result.segment_pattern = BLANK;

      if (key.found) begin
         if (key.code != last_key_ff) begin
            last_key_in      = key.code;
            result.key_event = 1'b1;
            result.key_code  = key.code;
            if (locked_ff) begin
               for (int i = 0; i < ENTRY_DEPTH; i++) begin
                  if (COUNT_W'(i) == count_ff) begin
                     entry_in[i] = key.code;
                  end
               end
               if (count_ff == COUNT_W'(CODE_LENGTH - 1)) begin
                  count_in = '0;
                  if (match) begin
                     locked_in            = 1'b0;
                     led_in               = LED_WHITE;
                     result.access_result = ACCESS_ALLOWED;
                  end else begin
                     result.access_result = ACCESS_DENIED;
                  end
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end else begin
               led_in                 = colour_of(key.code);
               result.display_update  = 1'b1;
               result.digit_select    = DIGIT_ZERO;
               result.segment_pattern = seg_of(key.code);
            end
         end
      end else if (last_key_ff != NO_KEY) begin
         // all keys released
         last_key_in = NO_KEY;
         if (locked_ff) begin
            led_in = LED_WHITE;
         end else begin
            led_in                = LED_OFF;
            result.display_update = 1'b1;
         end
      end

      result.lock_state    = locked_in;
      result.red_drive_n   = led_in[2];
      result.green_drive_n = led_in[1];
      result.blue_drive_n  = led_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= NO_KEY;
         count_ff    <= '0;
         locked_ff   <= 1'b1;
         led_ff      <= LED_WHITE;
      end else if (accept) begin
         last_key_ff <= last_key_in;
         count_ff    <= count_in;
         locked_ff   <= locked_in;
         led_ff      <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

### rtl/kcl_out_skid.sv
`default_nettype none

module kcl_out_skid
   import kcl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire result_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid && in_ready) begin
         // output stalled: park the new result
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
